[hdl/cubic_bezier_segment_sampler_macros.svh]
// ----------------------------------------------------------------------------
// cubic bezier segment sampler assertion macros
// concurrent checks on clk with synchronous reset rst; empty when SYNTH is set
// ----------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_SEGMENT_SAMPLER_MACROS_SVH
`define CUBIC_BEZIER_SEGMENT_SAMPLER_MACROS_SVH

`ifndef SYNTH

// overlapping implication checked on every rising edge outside reset
`define CBS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error("cbs check failed");

// next-cycle implication checked on every rising edge outside reset
`define CBS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
    else $error("cbs check failed");

`else

`define CBS_ASSERT_IMP(label, ante, cons)
`define CBS_ASSERT_NXT(label, ante, cons)

`endif

`endif

[hdl/cbs_pkg.sv]
// ----------------------------------------------------------------------------
// cbs_pkg
// shared widths, types and the reciprocal table of the bezier sampler
// ----------------------------------------------------------------------------
`default_nettype none

package cbs_pkg;

  // coordinate format and sample count limits
  localparam int COORD_BITS  = 32;
  localparam int MAX_SAMPLES = 64;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int PC_W        = 7;
  localparam int REM_W       = CNT_W + 1;

  // curve parameter t is unsigned q16, one integer bit for t = 1
  localparam int T_FRAC = 16;
  localparam int T_W    = T_FRAC + 1;
  localparam logic [T_W-1:0] ONE_T = T_W'(1) << T_FRAC;

  // bernstein products and rounded weights
  localparam int SQ_W   = 2 * T_W;
  localparam int CUBE_W = 3 * T_W;
  localparam int W_BITS = 56 - COORD_BITS;
  localparam int W_DROP = 3 * T_FRAC - W_BITS;
  localparam int WT_W   = W_BITS + 1;

  // blend datapath
  localparam int OPND_W = COORD_BITS + 1;
  localparam int PROD_W = WT_W + 1 + OPND_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int RND_W  = SUM_W + 1 - (W_BITS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_RUN
  } seq_state_t;

  // operands of one axis: 2*p0, p0+q, p3+q, 2*p3
  typedef struct packed {
    logic signed [OPND_W-1:0] p0x2;
    logic signed [OPND_W-1:0] c1;
    logic signed [OPND_W-1:0] c2;
    logic signed [OPND_W-1:0] p3x2;
  } axis_opnd_t;

  typedef struct packed {
    axis_opnd_t [2:0] axis;
  } opnd_t;

  // one curve parameter on its way into the evaluator
  typedef struct packed {
    logic           valid;
    logic           last;
    logic [T_W-1:0] t;
  } sample_t;

  // rounded bernstein weights of one sample
  typedef struct packed {
    logic            valid;
    logic            last;
    logic [WT_W-1:0] w0;
    logic [WT_W-1:0] w1;
    logic [WT_W-1:0] w2;
    logic [WT_W-1:0] w3;
  } wgt_t;

  // floor(2^16 / n) for n = 1 .. MAX_SAMPLES
  function automatic logic [T_W-1:0] recip_q(input logic [CNT_W-1:0] n);
    logic [T_W-1:0] q;
    case (n)
      7'd1:  q = 17'd65536;
      7'd2:  q = 17'd32768;
      7'd3:  q = 17'd21845;
      7'd4:  q = 17'd16384;
      7'd5:  q = 17'd13107;
      7'd6:  q = 17'd10922;
      7'd7:  q = 17'd9362;
      7'd8:  q = 17'd8192;
      7'd9:  q = 17'd7281;
      7'd10: q = 17'd6553;
      7'd11: q = 17'd5957;
      7'd12: q = 17'd5461;
      7'd13: q = 17'd5041;
      7'd14: q = 17'd4681;
      7'd15: q = 17'd4369;
      7'd16: q = 17'd4096;
      7'd17: q = 17'd3855;
      7'd18: q = 17'd3640;
      7'd19: q = 17'd3449;
      7'd20: q = 17'd3276;
      7'd21: q = 17'd3120;
      7'd22: q = 17'd2978;
      7'd23: q = 17'd2849;
      7'd24: q = 17'd2730;
      7'd25: q = 17'd2621;
      7'd26: q = 17'd2520;
      7'd27: q = 17'd2427;
      7'd28: q = 17'd2340;
      7'd29: q = 17'd2259;
      7'd30: q = 17'd2184;
      7'd31: q = 17'd2114;
      7'd32: q = 17'd2048;
      7'd33: q = 17'd1985;
      7'd34: q = 17'd1927;
      7'd35: q = 17'd1872;
      7'd36: q = 17'd1820;
      7'd37: q = 17'd1771;
      7'd38: q = 17'd1724;
      7'd39: q = 17'd1680;
      7'd40: q = 17'd1638;
      7'd41: q = 17'd1598;
      7'd42: q = 17'd1560;
      7'd43: q = 17'd1524;
      7'd44: q = 17'd1489;
      7'd45: q = 17'd1456;
      7'd46: q = 17'd1424;
      7'd47: q = 17'd1394;
      7'd48: q = 17'd1365;
      7'd49: q = 17'd1337;
      7'd50: q = 17'd1310;
      7'd51: q = 17'd1285;
      7'd52: q = 17'd1260;
      7'd53: q = 17'd1236;
      7'd54: q = 17'd1213;
      7'd55: q = 17'd1191;
      7'd56: q = 17'd1170;
      7'd57: q = 17'd1149;
      7'd58: q = 17'd1129;
      7'd59: q = 17'd1110;
      7'd60: q = 17'd1092;
      7'd61: q = 17'd1074;
      7'd62: q = 17'd1057;
      7'd63: q = 17'd1040;
      7'd64: q = 17'd1024;
      default: q = '0;
    endcase
    return q;
  endfunction

endpackage

`default_nettype wire

[hdl/cbs_seq.sv]
// ----------------------------------------------------------------------------
// cbs_seq
// takes a request, forms the control point operands and issues t = i/n,
// rounded to nearest, one sample per cycle by an incremental quotient
// ----------------------------------------------------------------------------
`default_nettype none

module cbs_seq (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [cbs_pkg::COORD_BITS-1:0] start_x,
  input  wire logic [cbs_pkg::COORD_BITS-1:0] start_y,
  input  wire logic [cbs_pkg::COORD_BITS-1:0] start_z,
  input  wire logic [cbs_pkg::COORD_BITS-1:0] end_x,
  input  wire logic [cbs_pkg::COORD_BITS-1:0] end_y,
  input  wire logic [cbs_pkg::COORD_BITS-1:0] end_z,
  input  wire logic [cbs_pkg::COORD_BITS-1:0] center_x,
  input  wire logic [cbs_pkg::COORD_BITS-1:0] center_y,
  input  wire logic [cbs_pkg::COORD_BITS-1:0] center_z,
  input  wire logic [cbs_pkg::PC_W-1:0]       point_count,
  output cbs_pkg::sample_t                    smp,
  output cbs_pkg::opnd_t                      opnd
);
  import cbs_pkg::*;

  // sign-extended operands of one axis
  function automatic axis_opnd_t make_axis(input logic [COORD_BITS-1:0] p0,
                                           input logic [COORD_BITS-1:0] p3,
                                           input logic [COORD_BITS-1:0] q);
    axis_opnd_t a;
    logic signed [OPND_W-1:0] p0e;
    logic signed [OPND_W-1:0] p3e;
    logic signed [OPND_W-1:0] qe;
    p0e    = {p0[COORD_BITS-1], p0};
    p3e    = {p3[COORD_BITS-1], p3};
    qe     = {q[COORD_BITS-1], q};
    a.p0x2 = {p0, 1'b0};
    a.p3x2 = {p3, 1'b0};
    a.c1   = p0e + qe;
    a.c2   = p3e + qe;
    return a;
  endfunction

  seq_state_t state;
  seq_state_t state_next;

  logic                     accept;
  logic                     issue;
  logic [CNT_W-1:0]         n_sat;
  logic [CNT_W-1:0]         n;
  logic [T_W-1:0]           qa;
  logic [REM_W-1:0]         ra;
  logic [T_W-1:0]           q;
  logic [REM_W-1:0]         r;
  logic [CNT_W-1:0]         i;
  logic [CNT_W+T_W-1:0]     nq;
  logic [CNT_W+T_W-1:0]     rem_full;
  logic [REM_W-1:0]         den;
  logic [REM_W-1:0]         r_sum;
  logic                     carry;
  logic [REM_W-1:0]         r_next;
  logic [T_W-1:0]           q_next;
  logic [CNT_W-1:0]         i_next;
  logic                     last_now;
  logic                     smp_valid;
  logic                     smp_last;
  logic [T_W-1:0]           smp_t;

  // request handshake and count saturation
  assign accept = start && !busy;
  assign n_sat  = (point_count > PC_W'(MAX_SAMPLES)) ? CNT_W'(MAX_SAMPLES)
                                                     : CNT_W'(point_count);

  // remainder of 2^17 over 2n is twice that of 2^16 over n
  assign nq       = n * qa;
  assign rem_full = (CNT_W + T_W)'(ONE_T) - nq;

  // one step of the running quotient (i * 2^17 + n) / 2n
  assign den      = {n, 1'b0};
  assign r_sum    = r + ra;
  assign carry    = (r_sum >= den);
  assign r_next   = carry ? (r_sum - den) : r_sum;
  assign q_next   = q + qa + T_W'(carry);
  assign i_next   = i + CNT_W'(1);
  assign last_now = (i_next == n);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (n_sat != '0)) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        state_next = ST_RUN;
      end
      ST_RUN: begin
        if (last_now) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    busy  = 1'b1;
    issue = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_PREP: begin
        busy = 1'b1;
      end
      ST_RUN: begin
        issue = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      smp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      smp_valid <= issue;
    end
  end

  // request capture and quotient registers
  always_ff @(posedge clk) begin
    if (accept) begin
      opnd.axis[0] <= make_axis(start_x, end_x, center_x);
      opnd.axis[1] <= make_axis(start_y, end_y, center_y);
      opnd.axis[2] <= make_axis(start_z, end_z, center_z);
      n            <= n_sat;
      qa           <= recip_q(n_sat);
    end
    if (state == ST_PREP) begin
      ra <= {rem_full[REM_W-2:0], 1'b0};
      q  <= '0;
      r  <= {1'b0, n};
      i  <= '0;
    end
    if (issue) begin
      q        <= q_next;
      r        <= r_next;
      i        <= i_next;
      smp_t    <= q_next;
      smp_last <= last_now;
    end
  end

  assign smp.valid = smp_valid;
  assign smp.last  = smp_last;
  assign smp.t     = smp_t;

endmodule

`default_nettype wire

[hdl/cbs_weights.sv]
// ----------------------------------------------------------------------------
// cbs_weights
// three-stage pipeline from t to the rounded bernstein weights u^3, 3u^2t,
// 3ut^2 and t^3; the request operands travel alongside
// ----------------------------------------------------------------------------
`default_nettype none

module cbs_weights (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire cbs_pkg::sample_t smp,
  input  wire cbs_pkg::opnd_t   opnd,
  output cbs_pkg::wgt_t         wgt,
  output cbs_pkg::opnd_t        wgt_opnd
);
  import cbs_pkg::*;

  localparam logic [CUBE_W-1:0] HALF_W = CUBE_W'(1) << (W_DROP - 1);

  // round a q48 product to the weight format, halves up
  function automatic logic [WT_W-1:0] round_w(input logic [CUBE_W-1:0] x);
    logic [CUBE_W-1:0] s;
    s = x + HALF_W;
    return s[W_DROP +: WT_W];
  endfunction

  logic [T_W-1:0]    u;
  logic              a_valid;
  logic              a_last;
  logic [T_W-1:0]    a_u;
  logic [T_W-1:0]    a_t;
  logic [SQ_W-1:0]   a_uu;
  logic [SQ_W-1:0]   a_ut;
  logic [SQ_W-1:0]   a_tt;
  opnd_t             a_opnd;
  logic              b_valid;
  logic              b_last;
  logic [CUBE_W-1:0] b_u3;
  logic [CUBE_W-1:0] b_uut;
  logic [CUBE_W-1:0] b_utt;
  logic [CUBE_W-1:0] b_t3;
  opnd_t             b_opnd;
  logic [CUBE_W-1:0] uut3;
  logic [CUBE_W-1:0] utt3;
  logic              c_valid;
  logic              c_last;
  logic [WT_W-1:0]   c_w0;
  logic [WT_W-1:0]   c_w1;
  logic [WT_W-1:0]   c_w2;
  logic [WT_W-1:0]   c_w3;

  assign u    = ONE_T - smp.t;
  assign uut3 = (b_uut << 1) + b_uut;
  assign utt3 = (b_utt << 1) + b_utt;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      a_valid <= smp.valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
  end

  // stage a: squares and cross product
  always_ff @(posedge clk) begin
    a_last <= smp.last;
    a_u    <= u;
    a_t    <= smp.t;
    a_uu   <= u * u;
    a_ut   <= u * smp.t;
    a_tt   <= smp.t * smp.t;
    a_opnd <= opnd;
  end

  // stage b: cubes
  always_ff @(posedge clk) begin
    b_last <= a_last;
    b_u3   <= a_uu * a_u;
    b_uut  <= a_ut * a_u;
    b_utt  <= a_ut * a_t;
    b_t3   <= a_tt * a_t;
    b_opnd <= a_opnd;
  end

  // stage c: scale by three and round
  always_ff @(posedge clk) begin
    c_last   <= b_last;
    c_w0     <= round_w(b_u3);
    c_w1     <= round_w(uut3);
    c_w2     <= round_w(utt3);
    c_w3     <= round_w(b_t3);
    wgt_opnd <= b_opnd;
  end

  assign wgt.valid = c_valid;
  assign wgt.last  = c_last;
  assign wgt.w0    = c_w0;
  assign wgt.w1    = c_w1;
  assign wgt.w2    = c_w2;
  assign wgt.w3    = c_w3;

endmodule

`default_nettype wire

[hdl/cbs_blend.sv]
// ----------------------------------------------------------------------------
// cbs_blend
// three-stage pipeline: weight times operand products, per-axis sum, then
// round to nearest with halves up and saturate to the coordinate range
// ----------------------------------------------------------------------------
`default_nettype none

module cbs_blend (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire cbs_pkg::wgt_t                wgt,
  input  wire cbs_pkg::opnd_t               wgt_opnd,
  output logic                              strobe,
  output logic [cbs_pkg::COORD_BITS-1:0]    out_x,
  output logic [cbs_pkg::COORD_BITS-1:0]    out_y,
  output logic [cbs_pkg::COORD_BITS-1:0]    out_z,
  output logic                              last_sample
);
  import cbs_pkg::*;

  localparam logic signed [SUM_W:0] RND_BIAS = (SUM_W + 1)'(1) << W_BITS;
  localparam logic signed [RND_W-1:0] SAT_MAX =
    {{(RND_W - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}};
  localparam logic signed [RND_W-1:0] SAT_MIN =
    {{(RND_W - COORD_BITS + 1){1'b1}}, {(COORD_BITS - 1){1'b0}}};

  logic                    d_valid;
  logic                    d_last;
  logic signed [PROD_W-1:0] d_prod [3][4];
  logic                    e_valid;
  logic                    e_last;
  logic signed [SUM_W-1:0] e_sum [3];
  logic signed [SUM_W:0]   biased [3];
  logic signed [RND_W-1:0] rounded [3];
  logic [COORD_BITS-1:0]   clamped [3];
  logic [COORD_BITS-1:0]   coord [3];

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
      e_valid <= 1'b0;
      strobe  <= 1'b0;
    end else begin
      d_valid <= wgt.valid;
      e_valid <= d_valid;
      strobe  <= e_valid;
    end
  end

  // stage d: twelve weight products
  always_ff @(posedge clk) begin
    d_last <= wgt.last;
    for (int k = 0; k < 3; k++) begin
      d_prod[k][0] <= $signed({1'b0, wgt.w0}) * $signed(wgt_opnd.axis[k].p0x2);
      d_prod[k][1] <= $signed({1'b0, wgt.w1}) * $signed(wgt_opnd.axis[k].c1);
      d_prod[k][2] <= $signed({1'b0, wgt.w2}) * $signed(wgt_opnd.axis[k].c2);
      d_prod[k][3] <= $signed({1'b0, wgt.w3}) * $signed(wgt_opnd.axis[k].p3x2);
    end
  end

  // stage e: per-axis sum
  always_ff @(posedge clk) begin
    e_last <= d_last;
    for (int k = 0; k < 3; k++) begin
      e_sum[k] <= SUM_W'(d_prod[k][0]) + SUM_W'(d_prod[k][1])
                + SUM_W'(d_prod[k][2]) + SUM_W'(d_prod[k][3]);
    end
  end

  // round by floor of the biased sum, then clamp
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      biased[k]  = (SUM_W + 1)'(e_sum[k]) + RND_BIAS;
      rounded[k] = biased[k][SUM_W : W_BITS + 1];
      if (rounded[k] > SAT_MAX) begin
        clamped[k] = SAT_MAX[COORD_BITS-1:0];
      end else if (rounded[k] < SAT_MIN) begin
        clamped[k] = SAT_MIN[COORD_BITS-1:0];
      end else begin
        clamped[k] = rounded[k][COORD_BITS-1:0];
      end
    end
  end

  // stage f: output registers
  always_ff @(posedge clk) begin
    last_sample <= e_last;
    for (int k = 0; k < 3; k++) begin
      coord[k] <= clamped[k];
    end
  end

  assign out_x = coord[0];
  assign out_y = coord[1];
  assign out_z = coord[2];

endmodule

`default_nettype wire

[hdl/cubic_bezier_segment_sampler.sv]
// ----------------------------------------------------------------------------
// cubic_bezier_segment_sampler
// after a request the sequencer prepares, then issues one t per cycle, and
// the outputs give one result a cycle; a zero count gives none. A new request
// is taken once the last t is issued; rst clears state and pipe valid bits
// ----------------------------------------------------------------------------
`default_nettype none
`include "cubic_bezier_segment_sampler_macros.svh"

module cubic_bezier_segment_sampler (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [cbs_pkg::COORD_BITS-1:0] start_x,
  input  wire logic [cbs_pkg::COORD_BITS-1:0] start_y,
  input  wire logic [cbs_pkg::COORD_BITS-1:0] start_z,
  input  wire logic [cbs_pkg::COORD_BITS-1:0] end_x,
  input  wire logic [cbs_pkg::COORD_BITS-1:0] end_y,
  input  wire logic [cbs_pkg::COORD_BITS-1:0] end_z,
  input  wire logic [cbs_pkg::COORD_BITS-1:0] center_x,
  input  wire logic [cbs_pkg::COORD_BITS-1:0] center_y,
  input  wire logic [cbs_pkg::COORD_BITS-1:0] center_z,
  input  wire logic [cbs_pkg::PC_W-1:0]       point_count,
  output logic                               strobe,
  output logic [cbs_pkg::COORD_BITS-1:0]      out_x,
  output logic [cbs_pkg::COORD_BITS-1:0]      out_y,
  output logic [cbs_pkg::COORD_BITS-1:0]      out_z,
  output logic                               last_sample
);
  import cbs_pkg::*;

  sample_t smp;
  opnd_t   opnd;
  wgt_t    wgt;
  opnd_t   wgt_opnd;

  // request capture and t sequencing
  cbs_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .start_x     (start_x),
    .start_y     (start_y),
    .start_z     (start_z),
    .end_x       (end_x),
    .end_y       (end_y),
    .end_z       (end_z),
    .center_x    (center_x),
    .center_y    (center_y),
    .center_z    (center_z),
    .point_count (point_count),
    .smp         (smp),
    .opnd        (opnd)
  );

  // bernstein weights
  cbs_weights u_weights (
    .clk      (clk),
    .rst      (rst),
    .smp      (smp),
    .opnd     (opnd),
    .wgt      (wgt),
    .wgt_opnd (wgt_opnd)
  );

  // weighted blend, rounding and saturation
  cbs_blend u_blend (
    .clk         (clk),
    .rst         (rst),
    .wgt         (wgt),
    .wgt_opnd    (wgt_opnd),
    .strobe      (strobe),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_z       (out_z),
    .last_sample (last_sample)
  );

  // a request with a nonzero count keeps the block busy
  `CBS_ASSERT_NXT(a_busy_after_req, start && !busy && (point_count != '0), busy)

  // the final t reaches the outputs through stages a to f, flagged as last
  `CBS_ASSERT_IMP(a_last_latency, smp.valid && smp.last, ##6 (strobe && last_sample))

  // busy drops only as the final t of a request is issued
  `CBS_ASSERT_IMP(a_busy_fall, $fell(busy), smp.valid && smp.last)

endmodule

`default_nettype wire
